FILE: hw/rtl/thc_pkg.sv
`default_nettype none
package thc_pkg;

	localparam logic [7:0] CFG_TEMP_ONE   = 8'd0;
	localparam logic [7:0] CFG_TEMP_TWO   = 8'd1;
	localparam logic [7:0] CFG_TEMP_THREE = 8'd2;
	localparam logic [7:0] CFG_HUM_ONE    = 8'd3;
	localparam logic [7:0] CFG_HUM_TWO    = 8'd4;
	localparam logic [7:0] CFG_HUM_THREE  = 8'd5;
	localparam logic [7:0] CFG_HUM_FOURFIVE = 8'd6;
	localparam logic [7:0] CFG_HUM_SIX    = 8'd7;

	localparam logic [31:0] FINE_OFFSET   = 32'd76800;
	localparam logic [31:0] HUM_ROUND_A   = 32'd16384;
	localparam logic [31:0] HUM_BIAS_B    = 32'd32768;
	localparam logic [31:0] HUM_BIAS_C    = 32'd2097152;
	localparam logic [31:0] HUM_ROUND_C   = 32'd8192;
	localparam logic [31:0] HUM_MAX       = 32'd419430400;
	localparam logic [31:0] TEMP_ROUND    = 32'd128;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} thc_request_t;

	typedef struct packed {
		logic signed [23:0] temperature_centi;
		logic signed [31:0] fine_temperature;
		logic        [16:0] humidity_q10;
	} thc_result_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [7:0]  h1;
		logic signed [15:0] h2;
		logic        [7:0]  h3;
		logic        [23:0] h45;
		logic signed [7:0]  h6;
	} thc_coeff_t;

	// temperature front end to humidity back end
	typedef struct packed {
		logic        [31:0] tfine;
		logic        [15:0] raw_humidity;
	} thc_temp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/thc_cfg.sv
`default_nettype none
module thc_cfg
	import thc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic [7:0] wr_index,
	input  wire logic [31:0] wr_data,
	output thc_coeff_t      coeff
);

	thc_coeff_t coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TEMP_ONE:     coeff_q.t1  <= wr_data[15:0];
				CFG_TEMP_TWO:     coeff_q.t2  <= wr_data[15:0];
				CFG_TEMP_THREE:   coeff_q.t3  <= wr_data[15:0];
				CFG_HUM_ONE:      coeff_q.h1  <= wr_data[7:0];
				CFG_HUM_TWO:      coeff_q.h2  <= wr_data[15:0];
				CFG_HUM_THREE:    coeff_q.h3  <= wr_data[7:0];
				CFG_HUM_FOURFIVE: coeff_q.h45 <= wr_data[23:0];
				CFG_HUM_SIX:      coeff_q.h6  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign coeff = coeff_q;

endmodule
`default_nettype wire

FILE: hw/rtl/thc_temp.sv
`default_nettype none
module thc_temp
	import thc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	input  wire thc_request_t req,
	input  wire thc_coeff_t  coeff,
	output logic        out_valid,
	output thc_temp_t   out_data
);

	logic [31:0] t1_w, t2_w, t3_w, dt_w, d_w;
	logic        v_s1, v_s2, v_s3;
	logic [31:0] p1_s1, dd_s1, v1_s2, q_s2, tfine_s3;
	logic [15:0] rh_s1, rh_s2, rh_s3;

	assign t1_w = {16'b0, coeff.t1};
	assign t2_w = {{16{coeff.t2[15]}}, coeff.t2};
	assign t3_w = {{16{coeff.t3[15]}}, coeff.t3};
	assign dt_w = {15'b0, req.raw_temperature[19:3]} - {15'b0, coeff.t1, 1'b0};
	assign d_w  = {16'b0, req.raw_temperature[19:4]} - t1_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// all products keep the low 32 bits only
	always_ff @(posedge clk) begin
		p1_s1    <= dt_w * t2_w;
		dd_s1    <= d_w * d_w;
		rh_s1    <= req.raw_humidity;
		v1_s2    <= 32'($signed(p1_s1) >>> 11);
		q_s2     <= 32'($signed(dd_s1) >>> 12) * t3_w;
		rh_s2    <= rh_s1;
		tfine_s3 <= v1_s2 + 32'($signed(q_s2) >>> 14);
		rh_s3    <= rh_s2;
	end

	assign out_valid             = v_s3;
	assign out_data.tfine        = tfine_s3;
	assign out_data.raw_humidity = rh_s3;

endmodule
`default_nettype wire

FILE: hw/rtl/thc_hum.sv
`default_nettype none
module thc_hum
	import thc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire thc_temp_t  in_data,
	input  wire thc_coeff_t coeff,
	output logic       out_valid,
	output thc_result_t out_data
);

	logic [31:0] x_w, h1_w, h2_w, h3_w, h4s_w, h5_w, h6_w, a_w, t5_w, b1_w, b_w, xf_w;
	logic [31:0] tc32_w;
	logic        v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [31:0] xh6_s4, xh3_s4, h5x_s4, tc32_s4;
	logic [31:0] tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9;
	logic [15:0] rh_s4;
	logic [23:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9;
	logic [31:0] a_s5, b0_s5, a_s6, bm_s6, xx_s7, xx_s8, sqsq_s8, xx_s9, m_s9;
	thc_result_t res_s10;

	assign h1_w  = {24'b0, coeff.h1};
	assign h2_w  = {{16{coeff.h2[15]}}, coeff.h2};
	assign h3_w  = {24'b0, coeff.h3};
	assign h4s_w = {coeff.h45[23:12], 20'b0};
	assign h5_w  = {20'b0, coeff.h45[11:0]};
	assign h6_w  = {{24{coeff.h6[7]}}, coeff.h6};

	assign x_w    = in_data.tfine - FINE_OFFSET;
	assign t5_w   = {in_data.tfine[29:0], 2'b0} + in_data.tfine + TEMP_ROUND;
	assign tc32_w = 32'($signed(t5_w) >>> 8);

	assign a_w  = {2'b0, rh_s4, 14'b0} - h4s_w - h5x_s4 + HUM_ROUND_A;
	assign b1_w = 32'($signed(b0_s5) >>> 10) + HUM_BIAS_C;
	assign b_w  = 32'($signed(bm_s6 + HUM_ROUND_C) >>> 14);
	assign xf_w = xx_s9 - 32'($signed(m_s9) >>> 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s4  <= in_valid;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		// s4: products of the offset fine temperature
		xh6_s4  <= x_w * h6_w;
		xh3_s4  <= x_w * h3_w;
		h5x_s4  <= h5_w * x_w;
		rh_s4   <= in_data.raw_humidity;
		tf_s4   <= in_data.tfine;
		tc32_s4 <= tc32_w;
		// s5: saturate temperature to 24 bits
		if ($signed(tc32_s4) > 32'sd8388607)
			tc_s5 <= 24'h7FFFFF;
		else if ($signed(tc32_s4) < -32'sd8388608)
			tc_s5 <= 24'h800000;
		else
			tc_s5 <= tc32_s4[23:0];
		a_s5  <= 32'($signed(a_w) >>> 15);
		b0_s5 <= 32'($signed(xh6_s4) >>> 10) * (32'($signed(xh3_s4) >>> 11) + HUM_BIAS_B);
		tf_s5 <= tf_s4;
		// s6
		a_s6  <= a_s5;
		bm_s6 <= b1_w * h2_w;
		tc_s6 <= tc_s5;
		tf_s6 <= tf_s5;
		// s7
		xx_s7 <= a_s6 * b_w;
		tc_s7 <= tc_s6;
		tf_s7 <= tf_s6;
		// s8
		xx_s8   <= xx_s7;
		sqsq_s8 <= 32'($signed(xx_s7) >>> 15) * 32'($signed(xx_s7) >>> 15);
		tc_s8   <= tc_s7;
		tf_s8   <= tf_s7;
		// s9
		xx_s9 <= xx_s8;
		m_s9  <= 32'($signed(sqsq_s8) >>> 7) * h1_w;
		tc_s9 <= tc_s8;
		tf_s9 <= tf_s8;
		// s10: clamp to 0..100 percent
		res_s10.temperature_centi <= tc_s9;
		res_s10.fine_temperature  <= tf_s9;
		if (xf_w[31])
			res_s10.humidity_q10 <= 17'd0;
		else if (xf_w > HUM_MAX)
			res_s10.humidity_q10 <= HUM_MAX[28:12];
		else
			res_s10.humidity_q10 <= xf_w[28:12];
	end

	assign out_valid = v_s10;
	assign out_data  = res_s10;

endmodule
`default_nettype wire

FILE: hw/rtl/temp_humidity_compensation.sv
// Throughput: one request per cycle; busy stays low, ten requests in flight at most.
// Rate is set by the ten-stage pipeline, at most one 32-bit product on any stage path.
// The receiver cannot stall: each result shows for one cycle with done.
// Reset (arst_n low) clears all coefficients to zero and drops requests in flight.
`default_nettype none
module temp_humidity_compensation
	import thc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire thc_request_t request,
	output logic             done,
	output thc_result_t      result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	thc_coeff_t coeff;
	logic       tf_valid;
	thc_temp_t  tf_data;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	thc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coeff    (coeff)
	);

	thc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.req       (request),
		.coeff     (coeff),
		.out_valid (tf_valid),
		.out_data  (tf_data)
	);

	thc_hum u_hum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tf_valid),
		.in_data   (tf_data),
		.coeff     (coeff),
		.out_valid (done),
		.out_data  (result)
	);

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##10 done)
		else $error("request did not complete after ten cycles");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.humidity_q10 <= 17'd102400))
		else $error("humidity beyond full scale");

	a_mid_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		tf_valid |-> ##7 done)
		else $error("humidity stages lost a request");
`endif

endmodule
`default_nettype wire
